>>> sv/sbr_pkg.sv
package sbr_pkg;

  // Field widths fixed by the stream format.
  localparam int POS_W = 32;
  localparam int BYTE_W = 8;
  localparam int CNT_PORT_W = 7;

  // Depths of the request queue and the result queue.
  localparam int REQ_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  // Action codes on the input side.
  localparam logic [1:0] ACT_SEGMENT = 2'd0;
  localparam logic [1:0] ACT_END     = 2'd1;
  localparam logic [1:0] ACT_CONSUME = 2'd2;

  // What the back end has to do with one request.
  typedef enum logic [1:0] {
    KIND_SEG,
    KIND_END,
    KIND_CONSUME,
    KIND_NOP
  } kind_t;

  // Classified request as it travels from the front to the back.
  typedef struct packed {
    kind_t                 kind;
    logic [POS_W-1:0]      pos;
    logic [BYTE_W-1:0]     data;
    logic                  end_valid;
    logic [POS_W-1:0]      end_cand;
    logic [CNT_PORT_W-1:0] consumed;
  } req_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic                  has_byte;
    logic [BYTE_W-1:0]     out_byte;
    logic                  last;
    logic                  stream_ended;
    logic                  conflict;
    logic [CNT_PORT_W-1:0] unassembled_count;
  } res_t;

endpackage

>>> sv/stream_byte_reassembler.sv
// Flow: the request queue takes requests while the back end works on one at a time;
// the back end pops a request in ST_IDLE, compares an overlapping byte in ST_CMP, scans
// the in-order run in ST_SCAN, then pushes a status result in ST_STATUS or reads and
// pushes each byte in ST_RD and ST_WR, waiting while the result queue is full.
// Reset: synchronous rst clears the queues, the valid marks, the counts and the next
// position, and sets the end position to all ones; the byte store is not cleared.
module stream_byte_reassembler #(
  parameter int CAPACITY = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     action,
  input  logic [sbr_pkg::POS_W-1:0]      byte_pos,
  input  logic [sbr_pkg::BYTE_W-1:0]     data_byte,
  input  logic                           segment_last,
  input  logic                           eof_flag,
  input  logic [sbr_pkg::CNT_PORT_W-1:0] consumed_count,
  output logic                           empty,
  input  logic                           pop,
  output logic                           has_byte,
  output logic [sbr_pkg::BYTE_W-1:0]     out_byte,
  output logic                           last,
  output logic                           stream_ended,
  output logic                           conflict,
  output logic [sbr_pkg::CNT_PORT_W-1:0] unassembled_count
);

  import sbr_pkg::*;

  req_t req;
  logic req_empty;
  logic req_pop;
  res_t res;

  // Front end: takes requests and classifies them.
  sbr_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .action         (action),
    .byte_pos       (byte_pos),
    .data_byte      (data_byte),
    .segment_last   (segment_last),
    .eof_flag       (eof_flag),
    .consumed_count (consumed_count),
    .req            (req),
    .req_empty      (req_empty),
    .req_pop        (req_pop)
  );

  // Back end: stores bytes and drains the in-order run.
  sbr_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_empty (req_empty),
    .req_pop   (req_pop),
    .res       (res),
    .res_empty (empty),
    .res_pop   (pop)
  );

  assign has_byte          = res.has_byte;
  assign out_byte          = res.out_byte;
  assign last              = res.last;
  assign stream_ended      = res.stream_ended;
  assign conflict          = res.conflict;
  assign unassembled_count = res.unassembled_count;

endmodule

>>> sv/sbr_ram.sv
module sbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/sbr_fifo.sv
module sbr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

>>> sv/sbr_front.sv
module sbr_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      action,
  input  logic [sbr_pkg::POS_W-1:0]       byte_pos,
  input  logic [sbr_pkg::BYTE_W-1:0]      data_byte,
  input  logic                            segment_last,
  input  logic                            eof_flag,
  input  logic [sbr_pkg::CNT_PORT_W-1:0]  consumed_count,
  output sbr_pkg::req_t                   req,
  output logic                            req_empty,
  input  logic                            req_pop
);

  import sbr_pkg::*;

  req_t             cls;
  logic [POS_W-1:0] pos_inc;

  // The end candidate for a final byte is one past it, held at all ones on overflow.
  assign pos_inc = (byte_pos == '1) ? byte_pos : byte_pos + 1'b1;

  // Classify the incoming request; none of this depends on stream state.
  always_comb begin
    cls.pos       = byte_pos;
    cls.data      = data_byte;
    cls.consumed  = consumed_count;
    cls.end_cand  = byte_pos;
    cls.end_valid = 1'b0;
    case (action)
      ACT_SEGMENT: begin
        cls.kind      = KIND_SEG;
        cls.end_cand  = pos_inc;
        cls.end_valid = eof_flag && segment_last;
      end
      ACT_END: begin
        cls.kind      = KIND_END;
        cls.end_valid = eof_flag;
      end
      ACT_CONSUME: begin
        cls.kind = KIND_CONSUME;
      end
      default: begin
        cls.kind = KIND_NOP;
      end
    endcase
  end

  // Short queue that lets the input side run ahead of the back end.
  sbr_fifo #(
    .WIDTH ($bits(req_t)),
    .DEPTH (REQ_DEPTH)
  ) u_req_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cls),
    .full  (full),
    .pop   (req_pop),
    .rdata (req),
    .empty (req_empty)
  );

endmodule

>>> sv/sbr_back.sv
module sbr_back #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  sbr_pkg::req_t req,
  input  logic          req_empty,
  output logic          req_pop,
  output sbr_pkg::res_t res,
  output logic          res_empty,
  input  logic          res_pop
);

  import sbr_pkg::*;

  localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_SCAN,
    ST_STATUS,
    ST_RD,
    ST_WR
  } state_t;

  state_t              state;
  logic [POS_W-1:0]    next_pos;
  logic [SLOT_W-1:0]   next_slot;
  logic [POS_W-1:0]    end_pos;
  logic [CNT_W-1:0]    buffered;
  logic [CNT_W-1:0]    stored;
  logic [CAPACITY-1:0] valid;
  logic                conflict_r;
  logic [BYTE_W-1:0]   data_r;
  logic [POS_W-1:0]    scan_pos;
  logic [SLOT_W-1:0]   scan_slot;
  logic [CNT_W-1:0]    scan_cnt;
  logic [SLOT_W-1:0]   emit_slot;
  logic [CNT_W-1:0]    remaining;
  logic                ended_r;
  logic [CNT_W-1:0]    unasm_r;

  logic [POS_W:0]      diff;
  logic [CNT_W-1:0]    room;
  logic                in_win;
  logic [SLOT_W:0]     slot_sum;
  logic [SLOT_W-1:0]   in_slot;
  logic                scan_go;
  logic                res_full;
  logic                res_push;
  res_t                res_data;
  logic                ram_we;
  logic                ram_re;
  logic [SLOT_W-1:0]   ram_raddr;
  logic [BYTE_W-1:0]   ram_rdata;

  // Window check: at or past next_pos, inside the free room, and before the end.
  assign diff     = {1'b0, req.pos} - {1'b0, next_pos};
  assign room     = CNT_W'(CAPACITY) - buffered;
  assign in_win   = !diff[POS_W] && (diff[POS_W-1:0] < POS_W'(room)) && (req.pos < end_pos);
  assign slot_sum = {1'b0, next_slot} + {1'b0, diff[SLOT_W-1:0]};
  assign in_slot  = (slot_sum >= (SLOT_W + 1)'(CAPACITY)) ?
                    SLOT_W'(slot_sum - (SLOT_W + 1)'(CAPACITY)) : slot_sum[SLOT_W-1:0];

  // The in-order run continues while below the end, under CAPACITY bytes, and the next slot is filled.
  assign scan_go = (scan_cnt < CNT_W'(CAPACITY)) && (scan_pos < end_pos) && valid[scan_slot];

  // Store access, request pop and result push for the current state.
  always_comb begin
    req_pop   = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = emit_slot;
    res_push  = 1'b0;
    res_data.has_byte          = 1'b0;
    res_data.out_byte          = '0;
    res_data.last              = 1'b1;
    res_data.stream_ended      = ended_r;
    res_data.conflict          = conflict_r;
    res_data.unassembled_count = CNT_PORT_W'(unasm_r);
    case (state)
      ST_IDLE: begin
        req_pop = !req_empty;
        if (!req_empty && req.kind == KIND_SEG && in_win) begin
          ram_we    = !valid[in_slot];
          ram_re    = valid[in_slot];
          ram_raddr = in_slot;
        end
      end
      ST_STATUS: begin
        res_push = !res_full;
      end
      ST_RD: begin
        ram_re = 1'b1;
      end
      ST_WR: begin
        res_push          = !res_full;
        res_data.has_byte = 1'b1;
        res_data.out_byte = ram_rdata;
        res_data.last     = (remaining == CNT_W'(1));
      end
      default: begin
      end
    endcase
  end

  // Sequencer: execute one request, scan the in-order run, then emit its results.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      next_pos   <= '0;
      next_slot  <= '0;
      end_pos    <= '1;
      buffered   <= '0;
      stored     <= '0;
      valid      <= '0;
      conflict_r <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!req_empty) begin
            conflict_r <= 1'b0;
            data_r     <= req.data;
            scan_pos   <= next_pos;
            scan_slot  <= next_slot;
            scan_cnt   <= '0;
            // A byte landing on a filled slot is compared before the scan.
            state      <= (req.kind == KIND_SEG && in_win && valid[in_slot]) ?
                          ST_CMP : ST_SCAN;
            case (req.kind)
              KIND_SEG: begin
                if (in_win && !valid[in_slot]) begin
                  valid[in_slot] <= 1'b1;
                  stored         <= stored + 1'b1;
                end
                if (req.end_valid && req.end_cand < end_pos) begin
                  end_pos <= req.end_cand;
                end
              end
              KIND_END: begin
                if (req.end_valid && req.end_cand < end_pos) begin
                  end_pos <= req.end_cand;
                end
              end
              KIND_CONSUME: begin
                if (req.consumed >= CNT_PORT_W'(buffered)) begin
                  buffered <= '0;
                end else begin
                  buffered <= buffered - CNT_W'(req.consumed);
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_CMP: begin
          conflict_r <= (ram_rdata != data_r);
          state      <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_go) begin
            scan_pos  <= scan_pos + 1'b1;
            scan_slot <= (scan_slot == SLOT_W'(CAPACITY - 1)) ? '0 : scan_slot + 1'b1;
            scan_cnt  <= scan_cnt + 1'b1;
          end else begin
            // Commit the whole run at once; the bytes are read out afterwards.
            ended_r   <= (scan_pos == end_pos);
            unasm_r   <= stored - scan_cnt;
            stored    <= stored - scan_cnt;
            buffered  <= buffered + scan_cnt;
            next_pos  <= scan_pos;
            next_slot <= scan_slot;
            emit_slot <= next_slot;
            remaining <= scan_cnt;
            state     <= (scan_cnt == '0) ? ST_STATUS : ST_RD;
          end
        end
        ST_STATUS: begin
          if (!res_full) begin
            state <= ST_IDLE;
          end
        end
        ST_RD: begin
          state <= ST_WR;
        end
        ST_WR: begin
          if (!res_full) begin
            valid[emit_slot] <= 1'b0;
            emit_slot <= (emit_slot == SLOT_W'(CAPACITY - 1)) ? '0 : emit_slot + 1'b1;
            remaining <= remaining - 1'b1;
            state     <= (remaining == CNT_W'(1)) ? ST_IDLE : ST_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Byte store; entries are read only where a valid mark is set.
  sbr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_slot),
    .wdata (req.data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result queue that buffers results while the reader stalls; when it is full the back end waits.
  sbr_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (res_pop),
    .rdata (res),
    .empty (res_empty)
  );

endmodule

>>> bench/stream_byte_reassembler_tb.sv
module stream_byte_reassembler_tb;
  import sbr_pkg::*;

  localparam int CAP = 64;
  localparam int LIMIT_CYCLES = 1500000;
  localparam int TARGET_ITEMS = 235;
  localparam int HOLD_AFTER_POPS = 40;
  localparam int HOLD_CYCLES = 250;
  localparam int TAIL_CYCLES = 250;
  localparam logic [1:0] ACT_NOP = 2'd3;

  // Results that can be typed in directly: a status result with no byte.
  localparam res_t NO_RES = '0;
  localparam res_t STATUS_0 = '{1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 7'd0};
  localparam res_t STATUS_1 = '{1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 7'd1};
  localparam res_t CLASH_1 = '{1'b0, 8'h00, 1'b1, 1'b0, 1'b1, 7'd1};

  logic clk;
  logic rst;
  logic push;
  logic full;
  logic [1:0] action;
  logic [POS_W-1:0] byte_pos;
  logic [BYTE_W-1:0] data_byte;
  logic segment_last;
  logic eof_flag;
  logic [CNT_PORT_W-1:0] consumed_count;
  logic empty;
  logic pop;
  logic has_byte;
  logic [BYTE_W-1:0] out_byte;
  logic last;
  logic stream_ended;
  logic conflict;
  logic [CNT_PORT_W-1:0] unassembled_count;

  stream_byte_reassembler #(.CAPACITY(CAP)) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .action(action),
    .byte_pos(byte_pos),
    .data_byte(data_byte),
    .segment_last(segment_last),
    .eof_flag(eof_flag),
    .consumed_count(consumed_count),
    .empty(empty),
    .pop(pop),
    .has_byte(has_byte),
    .out_byte(out_byte),
    .last(last),
    .stream_ended(stream_ended),
    .conflict(conflict),
    .unassembled_count(unassembled_count)
  );

  // One directed request; rel rows are placed relative to the stream position
  // reached when the closing rows start.
  typedef struct {
    logic [1:0] act;
    bit rel;
    logic [31:0] pos;
    logic [7:0] data;
    logic seg_last;
    logic eof;
    logic [6:0] consumed;
    bit typed;
    res_t want;
  } stim_row_t;

  localparam int OPEN_ROWS = 15;
  localparam int ALL_ROWS = 25;

  stim_row_t stim_plan [ALL_ROWS] = '{
    // Opening rows, straight after reset.
    '{ACT_SEGMENT, 1'b0, 32'd1, 8'hAA, 1'b0, 1'b0, 7'd0, 1'b1, STATUS_1},
    '{ACT_SEGMENT, 1'b0, 32'd1, 8'h55, 1'b0, 1'b0, 7'd0, 1'b1, CLASH_1},
    '{ACT_SEGMENT, 1'b0, 32'd0, 8'h00, 1'b1, 1'b0, 7'd0, 1'b0, NO_RES},
    '{ACT_SEGMENT, 1'b0, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1, 7'd0, 1'b1, STATUS_0},
    '{ACT_SEGMENT, 1'b0, 32'd64, 8'h3C, 1'b1, 1'b0, 7'd0, 1'b1, STATUS_0},
    '{ACT_CONSUME, 1'b0, 32'd0, 8'h00, 1'b0, 1'b0, 7'd64, 1'b1, STATUS_0},
    '{ACT_CONSUME, 1'b0, 32'd0, 8'h00, 1'b0, 1'b0, 7'd0, 1'b1, STATUS_0},
    '{ACT_SEGMENT, 1'b0, 32'd65, 8'hC3, 1'b0, 1'b0, 7'd0, 1'b1, STATUS_1},
    '{ACT_SEGMENT, 1'b0, 32'd66, 8'h11, 1'b1, 1'b0, 7'd0, 1'b1, STATUS_1},
    '{ACT_NOP, 1'b0, 32'd2, 8'h00, 1'b0, 1'b1, 7'd5, 1'b1, STATUS_1},
    '{ACT_END, 1'b0, 32'd2, 8'h00, 1'b0, 1'b0, 7'd0, 1'b1, STATUS_1},
    '{ACT_SEGMENT, 1'b0, 32'd2, 8'h80, 1'b0, 1'b0, 7'd0, 1'b0, NO_RES},
    '{ACT_SEGMENT, 1'b0, 32'd3, 8'hFF, 1'b1, 1'b0, 7'd0, 1'b0, NO_RES},
    '{ACT_SEGMENT, 1'b0, 32'd4, 8'h7F, 1'b0, 1'b1, 7'd0, 1'b0, NO_RES},
    '{ACT_CONSUME, 1'b0, 32'd0, 8'h00, 1'b0, 1'b0, 7'd1, 1'b1, STATUS_1},
    // Closing rows: the end is set, lowered, reached, and then nothing moves.
    '{ACT_CONSUME, 1'b0, 32'd0, 8'h00, 1'b0, 1'b0, 7'd64, 1'b0, NO_RES},
    '{ACT_SEGMENT, 1'b1, 32'd3, 8'h21, 1'b1, 1'b1, 7'd0, 1'b0, NO_RES},
    '{ACT_END, 1'b1, 32'd2, 8'h00, 1'b0, 1'b1, 7'd0, 1'b0, NO_RES},
    '{ACT_SEGMENT, 1'b1, 32'd0, 8'h42, 1'b1, 1'b0, 7'd0, 1'b0, NO_RES},
    '{ACT_SEGMENT, 1'b1, 32'd1, 8'h43, 1'b1, 1'b1, 7'd0, 1'b0, NO_RES},
    '{ACT_SEGMENT, 1'b1, 32'd2, 8'h44, 1'b1, 1'b0, 7'd0, 1'b0, NO_RES},
    '{ACT_END, 1'b1, 32'd5, 8'h00, 1'b0, 1'b1, 7'd0, 1'b0, NO_RES},
    '{ACT_SEGMENT, 1'b1, 32'd0, 8'h45, 1'b1, 1'b0, 7'd0, 1'b0, NO_RES},
    '{ACT_CONSUME, 1'b0, 32'd0, 8'h00, 1'b0, 1'b0, 7'd64, 1'b0, NO_RES},
    '{ACT_NOP, 1'b0, 32'd0, 8'h00, 1'b0, 1'b0, 7'd0, 1'b0, NO_RES}
  };

  // Shadow copy of the reassembly state.
  logic exp_valid [CAP];
  logic [7:0] exp_store [CAP];
  logic [31:0] exp_next_pos;
  logic [31:0] exp_end_pos;
  logic [31:0] exp_base;
  int exp_in_flight;
  int exp_held;

  res_t released [$];
  res_t pending_out [$];
  res_t oldest;
  int sent_count;
  int errors;
  int cycles;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Each side draws a random idle wait per item, with idle-free stretches.
  function automatic int idle_draw(input int count);
    if ((count / 24) % 3 == 2) return 0;
    return $urandom_range(0, 11);
  endfunction

  // Payload of the well-formed stream, so that overlapping bytes agree.
  function automatic logic [7:0] stream_byte(input logic [31:0] p);
    return p[7:0] ^ p[15:8] ^ 8'hA5;
  endfunction

  // Applies one request to the shadow state and fills released with the
  // results it causes: one per drained byte, or a single status result.
  function automatic void reassemble(input logic [1:0] act, input logic [31:0] pos,
                                     input logic [7:0] data, input logic seg_last,
                                     input logic eof, input logic [6:0] consumed);
    bit clash;
    longint win_end;
    logic [5:0] slot;
    res_t r;
    clash = 1'b0;
    released.delete();
    case (act)
      ACT_SEGMENT: begin
        // A byte is kept only inside the free window and before the end.
        win_end = longint'(exp_next_pos) + CAP - exp_in_flight;
        if (pos >= exp_next_pos && longint'(pos) < win_end && pos < exp_end_pos) begin
          slot = pos[5:0];
          if (exp_valid[slot]) begin
            clash = (exp_store[slot] != data);
          end else begin
            exp_store[slot] = data;
            exp_valid[slot] = 1'b1;
            exp_held++;
          end
        end
        // An end past the last position saturates at all ones, which never
        // lowers the current end.
        if (eof && seg_last && pos != 32'hFFFF_FFFF && pos + 32'd1 < exp_end_pos) begin
          exp_end_pos = pos + 32'd1;
        end
      end
      ACT_END: begin
        if (eof && pos < exp_end_pos) exp_end_pos = pos;
      end
      ACT_CONSUME: begin
        exp_in_flight = (consumed >= exp_in_flight) ? 0 : exp_in_flight - consumed;
      end
      default: begin
      end
    endcase

    // Drain the contiguous run at the next position.
    while (exp_next_pos < exp_end_pos && released.size() < CAP &&
           exp_valid[exp_next_pos[5:0]]) begin
      slot = exp_next_pos[5:0];
      exp_valid[slot] = 1'b0;
      exp_held--;
      exp_in_flight++;
      r = NO_RES;
      r.has_byte = 1'b1;
      r.out_byte = exp_store[slot];
      released = {released, r};
      exp_next_pos++;
    end
    if (released.size() == 0) released = {released, NO_RES};
    foreach (released[k]) begin
      released[k].last = (k == released.size() - 1);
      released[k].stream_ended = (exp_next_pos == exp_end_pos);
      released[k].conflict = clash;
      released[k].unassembled_count = 7'(exp_held);
    end
  endfunction

  // Offers one request after a random gap and records what it should produce
  // once it is taken.
  task automatic offer(input logic [1:0] act, input logic [31:0] pos,
                       input logic [7:0] data, input logic seg_last, input logic eof,
                       input logic [6:0] consumed, input bit typed, input res_t want);
    int gap;
    gap = idle_draw(sent_count);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    action = act;
    byte_pos = pos;
    data_byte = data;
    segment_last = seg_last;
    eof_flag = eof;
    consumed_count = consumed;
    push = 1'b1;
    do @(posedge clk); while (full);
    reassemble(act, pos, data, seg_last, eof, consumed);
    if (typed) begin
      pending_out = {pending_out, want};
    end else begin
      pending_out = {pending_out, released};
    end
    sent_count++;
    @(negedge clk);
  endtask

  task automatic offer_row(input int i);
    logic [31:0] pos;
    pos = stim_plan[i].rel ? exp_base + stim_plan[i].pos : stim_plan[i].pos;
    offer(stim_plan[i].act, pos, stim_plan[i].data, stim_plan[i].seg_last,
          stim_plan[i].eof, stim_plan[i].consumed, stim_plan[i].typed, stim_plan[i].want);
  endtask

  // A run of segment bytes; mostly stream payload, now and then a bad byte.
  task automatic send_segment(input longint first, input int len);
    longint p;
    logic [7:0] d;
    bit tail;
    for (int k = 0; k < len; k++) begin
      p = first + k;
      tail = (k == len - 1);
      d = ($urandom_range(0, 15) == 0) ? 8'($urandom) : stream_byte(p[31:0]);
      offer(ACT_SEGMENT, p[31:0], d, tail, tail ? 1'b0 : 1'($urandom), 7'($urandom),
            1'b0, NO_RES);
    end
  endtask

  // Random traffic: segments near the next position, segments at the window
  // edge, reader consumption, and a share of noise that is never counted.
  task automatic random_traffic();
    int items;
    int pick;
    int off;
    int len;
    longint first;
    logic sl;
    items = 0;
    while (items < TARGET_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 11) begin
        off = int'($urandom_range(0, 24)) - 4;
        first = longint'(exp_next_pos) + off;
        if (first < 0) first = 0;
        len = $urandom_range(1, 8);
        send_segment(first, len);
        items += len;
      end else if (pick < 13) begin
        first = longint'(exp_next_pos) + $urandom_range(40, 70);
        len = $urandom_range(1, 4);
        send_segment(first, len);
        items += len;
      end else if (pick < 17) begin
        offer(ACT_CONSUME, $urandom, 8'($urandom), 1'($urandom), 1'($urandom),
              7'($urandom_range(0, 64)), 1'b0, NO_RES);
        items++;
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            sl = 1'($urandom);
            offer(ACT_SEGMENT, $urandom, 8'($urandom), sl, sl ? 1'b0 : 1'($urandom),
                  7'($urandom), 1'b0, NO_RES);
          end
          1: begin
            offer(ACT_END, $urandom, 8'($urandom), 1'($urandom), 1'b0, 7'($urandom),
                  1'b0, NO_RES);
          end
          default: begin
            offer(ACT_NOP, $urandom, 8'($urandom), 1'($urandom), 1'($urandom),
                  7'($urandom), 1'b0, NO_RES);
          end
        endcase
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [7:0] want_v,
                                      input logic [7:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
    end
  endfunction

  // Compare every result taken by the reader with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_out.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, got byte %0h",
                 $time, out_byte);
      end else begin
        oldest = pending_out.pop_front();
        check_field("has_byte", oldest.has_byte, has_byte);
        check_field("out_byte", oldest.out_byte, out_byte);
        check_field("last", oldest.last, last);
        check_field("stream_ended", oldest.stream_ended, stream_ended);
        check_field("conflict", oldest.conflict, conflict);
        check_field("unassembled_count", oldest.unassembled_count, unassembled_count);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Reader side: random waits per result, and one long hold-off so that the
  // block backs up into its request queue.
  initial begin
    int pops;
    int wait_n;
    pop = 1'b0;
    pops = 0;
    wait (!rst);
    @(negedge clk);
    forever begin
      wait_n = (pops == HOLD_AFTER_POPS) ? HOLD_CYCLES : idle_draw(pops);
      if (wait_n > 0) begin
        pop = 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      pop = 1'b1;
      do @(posedge clk); while (empty);
      pops++;
      @(negedge clk);
    end
  end

  // Sender side and end of run.
  initial begin
    errors = 0;
    cycles = 0;
    sent_count = 0;
    rst = 1'b1;
    push = 1'b0;
    action = ACT_SEGMENT;
    byte_pos = '0;
    data_byte = '0;
    segment_last = 1'b0;
    eof_flag = 1'b0;
    consumed_count = '0;
    for (int i = 0; i < CAP; i++) begin
      exp_valid[i] = 1'b0;
      exp_store[i] = 8'h00;
    end
    exp_next_pos = '0;
    exp_end_pos = 32'hFFFF_FFFF;
    exp_in_flight = 0;
    exp_held = 0;
    exp_base = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < OPEN_ROWS; i++) offer_row(i);
    random_traffic();
    exp_base = exp_next_pos;
    for (int i = OPEN_ROWS; i < ALL_ROWS; i++) offer_row(i);
    push = 1'b0;

    // Let the last results come out, then watch for strays.
    while (pending_out.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/sbr_pkg.sv
sv/sbr_ram.sv
sv/sbr_fifo.sv
sv/sbr_front.sv
sv/sbr_back.sv
sv/stream_byte_reassembler.sv
bench/stream_byte_reassembler_tb.sv
